// ===== rtl/ljc_pkg.sv =====
// ----------------------------------------------------------------------------
// ljc_pkg
// Shared types, constants and opcodes for the molecule pair energy block.
// ----------------------------------------------------------------------------
package ljc_pkg;

    localparam int ATOMS_PER_MOLECULE_DEF = 4;
    localparam int NUM_ATOM_REGS          = 4;
    localparam int PARAM_W                = 60;
    localparam int SCALE_W                = 32;
    localparam int CFG_INDEX_W            = 3;
    localparam int ENERGY_W               = 48;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ATOM_0        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ATOM_1        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ATOM_2        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ATOM_3        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COULOMB_SCALE = 3'd4;

    localparam logic [SCALE_W-1:0] COULOMB_SCALE_RESET = 32'd21762120;

    // switch band limits in Q.24 and the band slope
    localparam logic [63:0] R2_INNER = 64'd3527409664;
    localparam logic [63:0] R2_OUTER = 64'd3774873600;
    localparam logic [63:0] SWITCH_K = 64'd291184223;
    localparam logic [47:0] PWR_CAP  = 48'h8000_0000_0000;

    // cutoff zones
    localparam logic [1:0] ZONE_INNER = 2'd0;
    localparam logic [1:0] ZONE_BAND  = 2'd1;
    localparam logic [1:0] ZONE_OUTER = 2'd2;

    // shared unit opcodes
    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
        logic [1:0]         first_atom_index;
        logic [1:0]         second_atom_index;
        logic               last_pair;
    } in_item_t;

    typedef struct packed {
        logic signed [ENERGY_W-1:0] pair_energy;
        logic [1:0]                 cutoff_zone;
        logic                       saturated;
    } out_item_t;

    typedef struct packed {
        logic [PARAM_W-1:0] atom_a;
        logic [PARAM_W-1:0] atom_b;
        logic [SCALE_W-1:0] scale;
    } params_t;

    typedef struct packed {
        logic        start;
        logic [1:0]  op;
        logic [63:0] a;
        logic [63:0] b;
    } alu_req_t;

    typedef struct packed {
        logic         done;
        logic [127:0] res;
    } alu_resp_t;

endpackage

// ===== rtl/ljc_cfg.sv =====
// ----------------------------------------------------------------------------
// ljc_cfg
// Configuration registers and per-atom parameter selection.
// ----------------------------------------------------------------------------
module ljc_cfg #(
    parameter int ATOMS_PER_MOLECULE = ljc_pkg::ATOMS_PER_MOLECULE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [ljc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ljc_pkg::PARAM_W-1:0]         cfg_data,
    input  logic [1:0]                          idx_a,
    input  logic [1:0]                          idx_b,
    output ljc_pkg::params_t                    params
);

    logic [ljc_pkg::PARAM_W-1:0] atom_reg [ljc_pkg::NUM_ATOM_REGS];
    logic [ljc_pkg::SCALE_W-1:0] scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ljc_pkg::NUM_ATOM_REGS; i++)
            begin
                atom_reg[i] <= '0;
            end
            scale_reg <= ljc_pkg::COULOMB_SCALE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ljc_pkg::REG_ATOM_0:        atom_reg[0] <= cfg_data;
                ljc_pkg::REG_ATOM_1:        atom_reg[1] <= cfg_data;
                ljc_pkg::REG_ATOM_2:        atom_reg[2] <= cfg_data;
                ljc_pkg::REG_ATOM_3:        atom_reg[3] <= cfg_data;
                ljc_pkg::REG_COULOMB_SCALE: scale_reg   <= cfg_data[ljc_pkg::SCALE_W-1:0];
                default:                    ;
            endcase
        end
    end

    // atoms past the molecule size read as zero parameters
    always_comb
    begin
        params.atom_a = (32'(idx_a) < ATOMS_PER_MOLECULE) ? atom_reg[idx_a] : '0;
        params.atom_b = (32'(idx_b) < ATOMS_PER_MOLECULE) ? atom_reg[idx_b] : '0;
        params.scale  = scale_reg;
    end

endmodule

// ===== rtl/ljc_alu.sv =====
// ----------------------------------------------------------------------------
// ljc_alu
// Shared bit-serial unit: 64x64 multiply, 64/64 divide, 64-bit square root.
// ----------------------------------------------------------------------------
module ljc_alu (
    input  logic               clk,
    input  logic               rst_n,
    input  ljc_pkg::alu_req_t  req,
    output ljc_pkg::alu_resp_t resp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [1:0]  op_reg, op_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] hi_reg, hi_next;
    logic [63:0] lo_reg, lo_next;
    logic [63:0] opd_reg, opd_next;
    logic [63:0] bit_reg, bit_next;

    logic [64:0] mul_sum;
    logic [64:0] div_rs;
    logic [63:0] sq_t;

    assign mul_sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, opd_reg} : 65'd0);
    assign div_rs  = {hi_reg, lo_reg[63]};
    assign sq_t    = lo_reg + bit_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        opd_next  = opd_reg;
        bit_next  = bit_reg;
        if (!busy_reg && req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            bit_next  = 64'h4000_0000_0000_0000;
            case (req.op)
                ljc_pkg::OP_MUL:
                begin
                    hi_next  = '0;
                    lo_next  = req.b;
                    opd_next = req.a;
                    cnt_next = 7'd64;
                end
                ljc_pkg::OP_DIV:
                begin
                    hi_next  = '0;
                    lo_next  = req.a;
                    opd_next = req.b;
                    cnt_next = 7'd64;
                end
                default:
                begin
                    hi_next  = req.a;
                    lo_next  = '0;
                    opd_next = '0;
                    cnt_next = 7'd32;
                end
            endcase
        end
        else if (busy_reg)
        begin
            case (op_reg)
                ljc_pkg::OP_MUL:
                begin
                    hi_next = mul_sum[64:1];
                    lo_next = {mul_sum[0], lo_reg[63:1]};
                end
                ljc_pkg::OP_DIV:
                begin
                    if (div_rs >= {1'b0, opd_reg})
                    begin
                        hi_next = 64'(div_rs - {1'b0, opd_reg});
                        lo_next = {lo_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        hi_next = div_rs[63:0];
                        lo_next = {lo_reg[62:0], 1'b0};
                    end
                end
                default:
                begin
                    // one root bit per step
                    if (hi_reg >= sq_t)
                    begin
                        hi_next = hi_reg - sq_t;
                        lo_next = (lo_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        lo_next = lo_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
            endcase
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= ljc_pkg::OP_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        opd_reg <= opd_next;
        bit_reg <= bit_next;
    end

    always_comb
    begin
        resp.done = done_reg;
        if (op_reg == ljc_pkg::OP_MUL)
        begin
            resp.res = {hi_reg, lo_reg};
        end
        else
        begin
            resp.res = {64'd0, lo_reg};
        end
    end

endmodule

// ===== rtl/lj_coulomb_molecule_pair_energy.sv =====
// ----------------------------------------------------------------------------
// lj_coulomb_molecule_pair_energy
// Coulomb plus 12-6 Lennard-Jones energy between two molecules, one atom pair
// per item, with cutoff switching on the last pair.
// ----------------------------------------------------------------------------
// One item is one atom pair. A small sequencer runs every product, quotient
// and the square root of the pair through one shared bit-serial unit that
// works one bit a cycle. A full pair runs fifteen multiplies and divides,
// the root, an accumulate step and the accept step before the next item can
// be taken. A zero charge product skips the Coulomb divide, zero LJ
// parameters skip the five LJ steps and a zero distance skips the inverse
// divide. The last pair of a molecule pair adds the closest-approach divide
// and, when the closest approach lies in the band, the switch scaling. The
// input stalls while a pair is in work; a finished result waits in the
// output register and does not hold up the next item.
module lj_coulomb_molecule_pair_energy #(
    parameter int ATOMS_PER_MOLECULE = ljc_pkg::ATOMS_PER_MOLECULE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  ljc_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output ljc_pkg::out_item_t              out_data,
    input  logic                            cfg_write,
    input  logic [ljc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ljc_pkg::PARAM_W-1:0]     cfg_data
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SQX   = 5'd1;
    localparam logic [4:0] S_SQY   = 5'd2;
    localparam logic [4:0] S_SQZ   = 5'd3;
    localparam logic [4:0] S_INV   = 5'd4;
    localparam logic [4:0] S_QQ    = 5'd5;
    localparam logic [4:0] S_KQ    = 5'd6;
    localparam logic [4:0] S_ROOT  = 5'd7;
    localparam logic [4:0] S_CDIV  = 5'd8;
    localparam logic [4:0] S_SIG   = 5'd9;
    localparam logic [4:0] S_EPS   = 5'd10;
    localparam logic [4:0] S_SIG2  = 5'd11;
    localparam logic [4:0] S_XDIV  = 5'd12;
    localparam logic [4:0] S_X2    = 5'd13;
    localparam logic [4:0] S_X6    = 5'd14;
    localparam logic [4:0] S_X12   = 5'd15;
    localparam logic [4:0] S_LJM   = 5'd16;
    localparam logic [4:0] S_ACC   = 5'd17;
    localparam logic [4:0] S_R2MIN = 5'd18;
    localparam logic [4:0] S_FAC   = 5'd19;
    localparam logic [4:0] S_SCHI  = 5'd20;
    localparam logic [4:0] S_SCLO  = 5'd21;
    localparam logic [4:0] S_EMIT  = 5'd22;

    localparam logic [63:0] NUM_INV   = 64'h0100_0000_0000_0000;
    localparam logic [63:0] NUM_R2MIN = 64'h0001_0000_0000_0000;
    localparam logic signed [55:0] HUGE_TERM = 56'sh2_0000_0000_0000;
    localparam logic signed [57:0] E_MAX = 58'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [57:0] E_MIN = -58'sh0_8000_0000_0000;

    function automatic logic [30:0] abs_delta(logic [31:0] a, logic [31:0] b);
        logic signed [32:0] d;
        logic [32:0]        m;
        d = $signed({b[31], b}) - $signed({a[31], a});
        m = d[32] ? 33'(-d) : 33'(d);
        return (m[32:31] != 2'd0) ? 31'h7FFF_FFFF : m[30:0];
    endfunction

    // floor(p / 2^16) capped at 2^47
    function automatic logic [47:0] sat16(logic [127:0] p);
        if (p[127:64] != 64'd0 || p[63:16] > ljc_pkg::PWR_CAP)
            return ljc_pkg::PWR_CAP;
        return p[63:16];
    endfunction

    logic [4:0]          state_reg, state_next;
    logic                issued_reg, issued_next;
    ljc_pkg::in_item_t   item_reg, item_next;
    logic [30:0]         dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;
    logic [63:0]         r2_reg, r2_next;
    logic [31:0]         max_inv_reg, max_inv_next;
    logic                qsign_reg, qsign_next;
    logic [21:0]         qm_reg, qm_next;
    logic [53:0]         kq_reg, kq_next;
    logic [32:0]         root_reg, root_next;
    logic signed [55:0]  coul_reg, coul_next;
    logic signed [55:0]  lj_reg, lj_next;
    logic [23:0]         sig_reg, sig_next, eps_reg, eps_next;
    logic [47:0]         sig2_reg, sig2_next;
    logic [47:0]         x_reg, x_next, pw_reg, pw_next;
    logic [47:0]         dmag_reg, dmag_next;
    logic                dneg_reg, dneg_next;
    logic signed [47:0]  energy_reg, energy_next;
    logic                sat_reg, sat_next;
    logic [1:0]          zone_reg, zone_next;
    logic [47:0]         e_reg, e_next;
    logic [48:0]         r2min_reg, r2min_next;
    logic [24:0]         f_reg, f_next;
    logic [49:0]         part_reg, part_next;
    logic                out_valid_reg, out_valid_next;
    ljc_pkg::out_item_t  out_data_reg, out_data_next;

    ljc_pkg::params_t    params;
    ljc_pkg::alu_req_t   alu_req;
    ljc_pkg::alu_resp_t  alu_resp;

    logic [19:0]         qa, qb, qa_mag, qb_mag;
    logic [47:0]         x12;
    logic signed [57:0]  acc_sum;
    logic [47:0]         e_mag;
    logic [49:0]         scaled;
    logic [32:0]         inv_wide;
    logic [31:0]         inv_val;
    logic                last_out_free;

    ljc_cfg #(
        .ATOMS_PER_MOLECULE(ATOMS_PER_MOLECULE)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .idx_a     (item_reg.first_atom_index),
        .idx_b     (item_reg.second_atom_index),
        .params    (params)
    );

    ljc_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .resp  (alu_resp)
    );

    assign qa     = params.atom_a[19:0];
    assign qb     = params.atom_b[19:0];
    assign qa_mag = qa[19] ? (~qa + 20'd1) : qa;
    assign qb_mag = qb[19] ? (~qb + 20'd1) : qb;
    assign x12    = sat16(alu_resp.res);
    assign acc_sum = 58'(energy_reg) + 58'(coul_reg) + 58'(lj_reg);
    assign e_mag  = energy_reg[47] ? 48'(-energy_reg) : 48'(energy_reg);
    assign scaled = part_reg + 50'(alu_resp.res[73:24]);
    assign inv_wide = (alu_resp.res[63:32] != 32'd0) ? 33'h0_FFFF_FFFF
                                                     : {1'b0, alu_resp.res[31:0]};
    assign inv_val = (r2_reg == 64'd0) ? 32'hFFFF_FFFF : inv_wide[31:0];
    assign last_out_free = !out_valid_reg || !out_stall;

    // operands of the shared unit per step
    always_comb
    begin
        alu_req.start = 1'b0;
        alu_req.op    = ljc_pkg::OP_MUL;
        alu_req.a     = '0;
        alu_req.b     = '0;
        case (state_reg)
            S_SQX:  begin alu_req.a = 64'(dx_reg); alu_req.b = 64'(dx_reg); end
            S_SQY:  begin alu_req.a = 64'(dy_reg); alu_req.b = 64'(dy_reg); end
            S_SQZ:  begin alu_req.a = 64'(dz_reg); alu_req.b = 64'(dz_reg); end
            S_INV:
            begin
                alu_req.op = ljc_pkg::OP_DIV;
                alu_req.a  = NUM_INV;
                alu_req.b  = r2_reg;
            end
            S_QQ:   begin alu_req.a = 64'(qa_mag); alu_req.b = 64'(qb_mag); end
            S_KQ:   begin alu_req.a = 64'(params.scale); alu_req.b = 64'(qm_reg); end
            S_ROOT:
            begin
                alu_req.op = ljc_pkg::OP_SQRT;
                alu_req.a  = r2_reg;
            end
            S_CDIV:
            begin
                alu_req.op = ljc_pkg::OP_DIV;
                alu_req.a  = 64'(kq_reg);
                alu_req.b  = 64'({root_reg, 1'b0});
            end
            S_SIG:
            begin
                alu_req.a = 64'(params.atom_a[39:20]);
                alu_req.b = 64'(params.atom_b[39:20]);
            end
            S_EPS:
            begin
                alu_req.a = 64'(params.atom_a[59:40]);
                alu_req.b = 64'(params.atom_b[59:40]);
            end
            S_SIG2: begin alu_req.a = 64'(sig_reg); alu_req.b = 64'(sig_reg); end
            S_XDIV:
            begin
                alu_req.op = ljc_pkg::OP_DIV;
                alu_req.a  = {sig2_reg, 16'd0};
                alu_req.b  = r2_reg;
            end
            S_X2:   begin alu_req.a = 64'(x_reg); alu_req.b = 64'(x_reg); end
            S_X6:   begin alu_req.a = 64'(pw_reg); alu_req.b = 64'(x_reg); end
            S_X12:  begin alu_req.a = 64'(pw_reg); alu_req.b = 64'(pw_reg); end
            S_LJM:  begin alu_req.a = 64'(eps_reg); alu_req.b = 64'(dmag_reg); end
            S_R2MIN:
            begin
                alu_req.op = ljc_pkg::OP_DIV;
                alu_req.a  = NUM_R2MIN;
                alu_req.b  = 64'(max_inv_reg);
            end
            S_FAC:
            begin
                alu_req.a = ljc_pkg::R2_OUTER - 64'(r2min_reg);
                alu_req.b = ljc_pkg::SWITCH_K;
            end
            S_SCHI: begin alu_req.a = 64'(e_mag[47:24]); alu_req.b = 64'(f_reg); end
            S_SCLO: begin alu_req.a = 64'(e_mag[23:0]); alu_req.b = 64'(f_reg); end
            default: ;
        endcase
        if (state_reg != S_IDLE && state_reg != S_ACC && state_reg != S_EMIT
            && !issued_reg)
        begin
            alu_req.start = 1'b1;
        end
        // steps that finish without the shared unit
        if (state_reg == S_INV && r2_reg == 64'd0)
            alu_req.start = 1'b0;
        if (state_reg == S_CDIV && (kq_reg == 54'd0 || root_reg == 33'd0))
            alu_req.start = 1'b0;
        if (state_reg == S_XDIV && r2_reg == 64'd0)
            alu_req.start = 1'b0;
    end

    always_comb
    begin
        state_next     = state_reg;
        issued_next    = issued_reg;
        item_next      = item_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        dz_next        = dz_reg;
        r2_next        = r2_reg;
        max_inv_next   = max_inv_reg;
        qsign_next     = qsign_reg;
        qm_next        = qm_reg;
        kq_next        = kq_reg;
        root_next      = root_reg;
        coul_next      = coul_reg;
        lj_next        = lj_reg;
        sig_next       = sig_reg;
        eps_next       = eps_reg;
        sig2_next      = sig2_reg;
        x_next         = x_reg;
        pw_next        = pw_reg;
        dmag_next      = dmag_reg;
        dneg_next      = dneg_reg;
        energy_next    = energy_reg;
        sat_next       = sat_reg;
        zone_next      = zone_reg;
        e_next         = e_reg;
        r2min_next     = r2min_reg;
        f_next         = f_reg;
        part_next      = part_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (alu_req.start)
            issued_next = 1'b1;
        if (alu_resp.done)
            issued_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    dx_next    = abs_delta(in_data.ax, in_data.bx);
                    dy_next    = abs_delta(in_data.ay, in_data.by);
                    dz_next    = abs_delta(in_data.az, in_data.bz);
                    state_next = S_SQX;
                end
            end
            S_SQX:
            begin
                if (alu_resp.done)
                begin
                    r2_next    = alu_resp.res[63:0];
                    state_next = S_SQY;
                end
            end
            S_SQY:
            begin
                if (alu_resp.done)
                begin
                    r2_next    = r2_reg + alu_resp.res[63:0];
                    state_next = S_SQZ;
                end
            end
            S_SQZ:
            begin
                if (alu_resp.done)
                begin
                    r2_next    = r2_reg + alu_resp.res[63:0];
                    state_next = S_INV;
                end
            end
            S_INV:
            begin
                if (r2_reg == 64'd0 || alu_resp.done)
                begin
                    if (inv_val > max_inv_reg)
                        max_inv_next = inv_val;
                    state_next = S_QQ;
                end
            end
            S_QQ:
            begin
                if (alu_resp.done)
                begin
                    qm_next    = alu_resp.res[38:17];
                    qsign_next = qa[19] ^ qb[19];
                    state_next = S_KQ;
                end
            end
            S_KQ:
            begin
                if (alu_resp.done)
                begin
                    kq_next    = alu_resp.res[53:0];
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (alu_resp.done)
                begin
                    root_next  = alu_resp.res[32:0];
                    state_next = S_CDIV;
                end
            end
            S_CDIV:
            begin
                if (kq_reg == 54'd0)
                begin
                    coul_next  = '0;
                    state_next = S_SIG;
                end
                else if (root_reg == 33'd0)
                begin
                    coul_next  = qsign_reg ? -HUGE_TERM : HUGE_TERM;
                    state_next = S_SIG;
                end
                else if (alu_resp.done)
                begin
                    coul_next  = qsign_reg ? -$signed(56'(alu_resp.res[54:0]))
                                           : $signed(56'(alu_resp.res[54:0]));
                    state_next = S_SIG;
                end
            end
            S_SIG:
            begin
                if (alu_resp.done)
                begin
                    sig_next   = alu_resp.res[39:16];
                    state_next = S_EPS;
                end
            end
            S_EPS:
            begin
                if (alu_resp.done)
                begin
                    eps_next   = alu_resp.res[39:16];
                    state_next = S_SIG2;
                end
            end
            S_SIG2:
            begin
                if (alu_resp.done)
                begin
                    sig2_next = alu_resp.res[47:0];
                    if (eps_reg == 24'd0 || alu_resp.res[47:0] == 48'd0)
                    begin
                        lj_next    = '0;
                        state_next = S_ACC;
                    end
                    else
                    begin
                        state_next = S_XDIV;
                    end
                end
            end
            S_XDIV:
            begin
                if (r2_reg == 64'd0)
                begin
                    x_next     = ljc_pkg::PWR_CAP;
                    state_next = S_X2;
                end
                else if (alu_resp.done)
                begin
                    if (alu_resp.res[63:48] != 16'd0
                        || alu_resp.res[47:0] > ljc_pkg::PWR_CAP)
                        x_next = ljc_pkg::PWR_CAP;
                    else
                        x_next = alu_resp.res[47:0];
                    state_next = S_X2;
                end
            end
            S_X2:
            begin
                if (alu_resp.done)
                begin
                    pw_next    = sat16(alu_resp.res);
                    state_next = S_X6;
                end
            end
            S_X6:
            begin
                if (alu_resp.done)
                begin
                    pw_next    = sat16(alu_resp.res);
                    state_next = S_X12;
                end
            end
            S_X12:
            begin
                if (alu_resp.done)
                begin
                    if (x12 >= ljc_pkg::PWR_CAP)
                    begin
                        lj_next    = HUGE_TERM;
                        state_next = S_ACC;
                    end
                    else
                    begin
                        dneg_next  = x12 < pw_reg;
                        dmag_next  = (x12 < pw_reg) ? (pw_reg - x12) : (x12 - pw_reg);
                        state_next = S_LJM;
                    end
                end
            end
            S_LJM:
            begin
                if (alu_resp.done)
                begin
                    lj_next    = dneg_reg ? -$signed({6'd0, sat16(alu_resp.res), 2'd0})
                                          : $signed({6'd0, sat16(alu_resp.res), 2'd0});
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (acc_sum > E_MAX)
                begin
                    energy_next = E_MAX[47:0];
                    sat_next    = 1'b1;
                end
                else if (acc_sum < E_MIN)
                begin
                    energy_next = E_MIN[47:0];
                    sat_next    = 1'b1;
                end
                else
                begin
                    energy_next = acc_sum[47:0];
                end
                if (!item_reg.last_pair)
                begin
                    state_next = S_IDLE;
                end
                else if (max_inv_reg == 32'd0)
                begin
                    zone_next  = ljc_pkg::ZONE_OUTER;
                    e_next     = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_R2MIN;
                end
            end
            S_R2MIN:
            begin
                if (alu_resp.done)
                begin
                    r2min_next = alu_resp.res[48:0];
                    if (alu_resp.res[63:0] < ljc_pkg::R2_INNER)
                    begin
                        zone_next  = ljc_pkg::ZONE_INNER;
                        e_next     = energy_reg;
                        state_next = S_EMIT;
                    end
                    else if (alu_resp.res[63:0] < ljc_pkg::R2_OUTER)
                    begin
                        zone_next  = ljc_pkg::ZONE_BAND;
                        state_next = S_FAC;
                    end
                    else
                    begin
                        zone_next  = ljc_pkg::ZONE_OUTER;
                        e_next     = '0;
                        state_next = S_EMIT;
                    end
                end
            end
            S_FAC:
            begin
                if (alu_resp.done)
                begin
                    f_next     = alu_resp.res[56:32];
                    state_next = S_SCHI;
                end
            end
            S_SCHI:
            begin
                if (alu_resp.done)
                begin
                    part_next  = alu_resp.res[49:0];
                    state_next = S_SCLO;
                end
            end
            S_SCLO:
            begin
                if (alu_resp.done)
                begin
                    e_next     = energy_reg[47] ? 48'(-scaled) : scaled[47:0];
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (last_out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.pair_energy = e_reg;
                    out_data_next.cutoff_zone = zone_reg;
                    out_data_next.saturated   = sat_reg;
                    energy_next               = '0;
                    max_inv_next              = '0;
                    sat_next                  = 1'b0;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issued_reg    <= 1'b0;
            max_inv_reg   <= '0;
            energy_reg    <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            max_inv_reg   <= max_inv_next;
            energy_reg    <= energy_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // item_reg feeds the parameter select, so it is cleared too
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_reg <= '0;
        else
            item_reg <= item_next;
    end

    always_ff @(posedge clk)
    begin
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        dz_reg       <= dz_next;
        r2_reg       <= r2_next;
        qsign_reg    <= qsign_next;
        qm_reg       <= qm_next;
        kq_reg       <= kq_next;
        root_reg     <= root_next;
        coul_reg     <= coul_next;
        lj_reg       <= lj_next;
        sig_reg      <= sig_next;
        eps_reg      <= eps_next;
        sig2_reg     <= sig2_next;
        x_reg        <= x_next;
        pw_reg       <= pw_next;
        dmag_reg     <= dmag_next;
        dneg_reg     <= dneg_next;
        zone_reg     <= zone_next;
        e_reg        <= e_next;
        r2min_reg    <= r2min_next;
        f_reg        <= f_next;
        part_reg     <= part_next;
        out_data_reg <= out_data_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
